@@ rtl/overlap_add_accumulator_defines.svh @@
// assertion macros for the overlap-add accumulator
`ifndef OVERLAP_ADD_ACCUMULATOR_DEFINES_SVH
`define OVERLAP_ADD_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OAA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define OAA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/oaa_pkg.sv @@
// shared types, constants and saturation helpers for the overlap-add accumulator
package oaa_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int ENTRY_W     = 18;
  localparam int CHUNK_CFG_W = 9;
  localparam int HOP_CFG_W   = 7;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_ADDR_W-1:0] REG_CHUNK = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOP   = 1'b1;

  localparam logic [CHUNK_CFG_W-1:0] CHUNK_RESET = 9'd256;
  localparam logic [HOP_CFG_W-1:0]   HOP_RESET   = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    FEED_HEAD,
    FEED_ADD,
    FEED_ZERO
  } feed_sel_t;

  typedef struct packed {
    logic      shift;
    feed_sel_t feed_sel;
  } chain_ctl_t;

  // entry + sample, clipped to the 18-bit entry range
  function automatic logic signed [ENTRY_W-1:0] sat_entry(
    input logic signed [ENTRY_W:0] v
  );
    logic signed [ENTRY_W-1:0] r;
    if (v[ENTRY_W] != v[ENTRY_W-1]) begin
      r = v[ENTRY_W] ? {1'b1, {(ENTRY_W-1){1'b0}}} : {1'b0, {(ENTRY_W-1){1'b1}}};
    end else begin
      r = v[ENTRY_W-1:0];
    end
    return r;
  endfunction

  // entry clipped to a Q1.15 output sample
  function automatic logic signed [SAMPLE_W-1:0] sat_out(
    input logic signed [ENTRY_W-1:0] v
  );
    logic signed [SAMPLE_W-1:0] r;
    if ((v[ENTRY_W-1:SAMPLE_W-1] == '0) || (v[ENTRY_W-1:SAMPLE_W-1] == '1)) begin
      r = v[SAMPLE_W-1:0];
    end else begin
      r = v[ENTRY_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/oaa_cell.sv @@
// one accumulation cell of the rotating store
module oaa_cell import oaa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic signed [ENTRY_W-1:0] d,
  output logic signed [ENTRY_W-1:0] q
);

  logic signed [ENTRY_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (en) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

@@ rtl/oaa_chain.sv @@
// row of cells forming a ring of programmable length with a feed at the tail
module oaa_chain import oaa_pkg::*; #(
  parameter int DEPTH = 320,
  parameter int LEN_W = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chain_ctl_t                 ctl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [LEN_W-1:0]    ring_len,
  output logic signed [ENTRY_W-1:0]  head
);

  logic signed [ENTRY_W-1:0] cell_q [DEPTH];
  logic signed [ENTRY_W-1:0] feed;
  logic signed [ENTRY_W:0]   sum;
  logic        [LEN_W-1:0]   tail_idx;

  assign head     = cell_q[0];
  assign tail_idx = ring_len - 1'b1;
  assign sum      = {head[ENTRY_W-1], head}
                  + {{(ENTRY_W+1-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};

  always_comb begin
    case (ctl.feed_sel)
      FEED_ADD:  feed = sat_entry(sum);
      FEED_ZERO: feed = '0;
      default:   feed = head;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ENTRY_W-1:0] d;
    logic                      en;

    if (i == DEPTH - 1) begin : g_last
      assign d = feed;
    end else begin : g_mid
      assign d = (LEN_W'(i) == tail_idx) ? feed : cell_q[i+1];
    end

    // cells past the active length keep their contents
    assign en = ctl.shift && (LEN_W'(i) < ring_len);

    oaa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (d),
      .q     (cell_q[i])
    );
  end

endmodule

@@ rtl/overlap_add_accumulator.sv @@
// overlap-add accumulator top level: control, configuration and output stage
//
// channel | direction | tdata (low bit up)   | tlast           | handshake
// in_     | input     | sample[15:0]         | chunk_end       | in_tvalid & in_tready
// out_    | output    | out_sample[15:0]     | out_last        | out_tvalid & out_tready
// cfg_    | input     | cfg_wdata (reg data) | -               | cfg_we, index cfg_addr
//
// on a sample the store, a ring of cells, rotates one place,
// so the entry being added to always sits in the head cell
// a chunk end rotates the ring until entry zero is back at the head, then emits
// hop_length results from the head while zeros refill the tail
// a register change in mid-chunk realigns the store before the next sample is taken
// synchronous active-low reset clears every cell at once, no clearing pass
// emission pauses while the output register holds an untaken transfer
module overlap_add_accumulator import oaa_pkg::*; #(
  parameter int CHUNK_MAX = 256,
  parameter int HOP_MAX   = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  input  logic                  in_tlast,   // chunk_end
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,  // [15:0] out_sample
  output logic                  out_tlast,  // out_last
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  `include "overlap_add_accumulator_defines.svh"

  localparam int DEPTH = CHUNK_MAX + HOP_MAX;
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int HOP_W = $clog2(HOP_MAX + 1);
  localparam int CMP_W = LEN_W + CHUNK_CFG_W;

  // configuration registers
  logic [CHUNK_CFG_W-1:0] chunk_cfg_r;
  logic [HOP_CFG_W-1:0]   hop_cfg_r;

  // effective lengths after clamping
  logic [LEN_W-1:0] cur_chunk;
  logic [HOP_W-1:0] cur_hop;
  logic [LEN_W-1:0] cur_len;

  // control state
  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] widx_r;      // logical entry the next sample adds into
  logic [LEN_W-1:0] rot_r;       // logical entry now in the head cell
  logic [LEN_W-1:0] ring_len_r;  // length the ring is currently rotated over
  logic [HOP_W-1:0] emit_cnt_r;

  // output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;

  logic                      in_fire;
  logic                      in_range;
  logic                      len_change;
  logic                      seek;
  logic                      ring_load;
  logic                      emit_ok;
  logic                      emit_fire;
  logic                      emit_last;
  logic [LEN_W-1:0]          rot_inc;
  chain_ctl_t                ctl;
  logic signed [ENTRY_W-1:0] head;

  // clamp register values into their legal ranges
  always_comb begin
    if (chunk_cfg_r == '0) begin
      cur_chunk = LEN_W'(1);
    end else if (CMP_W'(chunk_cfg_r) > CMP_W'(CHUNK_MAX)) begin
      cur_chunk = LEN_W'(CHUNK_MAX);
    end else begin
      cur_chunk = LEN_W'(chunk_cfg_r);
    end
    if (hop_cfg_r == '0) begin
      cur_hop = HOP_W'(1);
    end else if (HOP_CFG_W'(hop_cfg_r) > HOP_CFG_W'(HOP_MAX)) begin
      cur_hop = HOP_W'(HOP_MAX);
    end else begin
      cur_hop = HOP_W'(hop_cfg_r);
    end
  end

  assign cur_len = cur_chunk + LEN_W'(cur_hop);

  assign in_range   = widx_r < cur_len;
  assign len_change = ring_len_r != cur_len;
  // after a length change, unwind the old ring back to entry zero, then
  // rotate the new ring until the write entry sits at the head
  assign seek       = len_change ? (rot_r != '0) : (in_range && (rot_r != widx_r));
  assign rot_inc    = (rot_r == ring_len_r - 1'b1) ? '0 : rot_r + 1'b1;
  assign emit_ok    = !out_valid_r || out_tready;
  assign emit_last  = emit_cnt_r == cur_hop - 1'b1;
  assign in_fire    = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_tlast) begin
          state_nxt = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (rot_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready    = 1'b0;
    ring_load    = 1'b0;
    emit_fire    = 1'b0;
    ctl.shift    = 1'b0;
    ctl.feed_sel = FEED_HEAD;
    case (state_r)
      ST_IDLE: begin
        if (len_change && !seek) begin
          ring_load = 1'b1;
        end else if (seek) begin
          ctl.shift = 1'b1;
        end else begin
          in_tready = !cfg_we;
          if (in_tvalid && !cfg_we && in_range) begin
            ctl.shift    = 1'b1;
            ctl.feed_sel = FEED_ADD;
          end
        end
      end
      ST_ALIGN: begin
        // bring logical entry zero back to the head
        ctl.shift = rot_r != '0;
      end
      ST_EMIT: begin
        // head goes out, zero refills the tail; hop rotations leave the
        // shifted store with entry zero at the head again
        if (emit_ok) begin
          emit_fire    = 1'b1;
          ctl.shift    = 1'b1;
          ctl.feed_sel = FEED_ZERO;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      widx_r      <= '0;
      rot_r       <= '0;
      ring_len_r  <= '0;
      emit_cnt_r  <= '0;
      chunk_cfg_r <= CHUNK_RESET;
      hop_cfg_r   <= HOP_RESET;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          REG_CHUNK: chunk_cfg_r <= cfg_wdata[CHUNK_CFG_W-1:0];
          REG_HOP:   hop_cfg_r   <= cfg_wdata[HOP_CFG_W-1:0];
          default: ;
        endcase
      end

      if (ring_load) begin
        ring_len_r <= cur_len;
      end

      if (ctl.shift && (ctl.feed_sel != FEED_ZERO)) begin
        rot_r <= rot_inc;
      end

      if (in_fire) begin
        if (in_tlast) begin
          widx_r <= '0;
        end else if (in_range) begin
          widx_r <= widx_r + 1'b1;
        end
      end

      if (emit_fire) begin
        emit_cnt_r <= emit_last ? '0 : emit_cnt_r + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_sample_r <= sat_out(head);
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_last_r;

  oaa_chain #(
    .DEPTH (DEPTH),
    .LEN_W (LEN_W)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sample   (in_tdata),
    .ring_len (ring_len_r),
    .head     (head)
  );

  // a sample is only taken with its entry at the head or outside the store
  `OAA_ASSERT_IMP(a_head_aligned, clk, rst_n, in_tready, (rot_r == widx_r) || (widx_r >= cur_len) || (ring_len_r != cur_len), "sample taken with store misaligned")
  // a chunk end always starts the alignment sweep
  `OAA_ASSERT_NXT(a_end_aligns, clk, rst_n, in_fire && in_tlast, state_r == ST_ALIGN, "chunk end did not start alignment")
  // emission reads the store with entry zero at the head
  `OAA_ASSERT_IMP(a_emit_at_zero, clk, rst_n, state_r == ST_EMIT, rot_r == '0, "emission with store rotated")
  // the last emitted transfer carries the last flag and ends the burst
  `OAA_ASSERT_NXT(a_emit_last, clk, rst_n, emit_fire && emit_last, (state_r == ST_IDLE) && out_tvalid && out_tlast, "last emit not flagged")

endmodule

@@ bench/overlap_add_accumulator_test.sv @@
// self-checking stream bench for the overlap-add accumulator
module overlap_add_accumulator_test import oaa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHUNK_MAX    = 256;
  localparam int HOP_MAX      = 64;
  localparam int STORE_DEPTH  = CHUNK_MAX + HOP_MAX;
  // settle wait after input covers the worst realignment after a size change
  localparam int SETTLE_CYCLES = 2 * STORE_DEPTH + 16;
  localparam int RANDOM_ITEMS  = 270;
  localparam int ENTRY_TOP     = 131071;
  localparam int ENTRY_BOTTOM  = -131072;
  localparam int CHUNK_CAP     = 24;   // keeps big-chunk settings short

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_SET_CHUNK,
    ROW_SET_HOP
  } row_kind_t;

  // one line of the directed table; pinned rows carry a hand-typed first result
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_DATA_W-1:0]   value;
    logic [SAMPLE_W-1:0]     smp;
    logic                    chunk_end;
    logic                    pinned;
    logic [SAMPLE_W-1:0]     first_out;
  } plan_row_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                last;
  } out_beat_t;

  localparam int PLAN_ROWS = 23;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // reset sizes (256/64): two one-sample chunks, 64 results each
    '{ROW_SAMPLE,    9'd0,     16'h7fff, 1'b1, 1'b1, 16'h7fff},
    '{ROW_SAMPLE,    9'd0,     16'h8000, 1'b1, 1'b1, 16'h8000},
    // zero sizes behave as one: store of two entries
    '{ROW_SET_CHUNK, 9'd0,     16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SET_HOP,   9'd0,     16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SAMPLE,    9'd0,     16'h7fff, 1'b0, 1'b0, 16'h0000},
    '{ROW_SAMPLE,    9'd0,     16'h7fff, 1'b0, 1'b0, 16'h0000},
    // third sample falls past the store and is dropped
    '{ROW_SAMPLE,    9'd0,     16'h1234, 1'b1, 1'b1, 16'h7fff},
    // shifted 32767 plus 32767 clips on the way out
    '{ROW_SAMPLE,    9'd0,     16'h7fff, 1'b1, 1'b1, 16'h7fff},
    // hop longer than the chunk
    '{ROW_SET_CHUNK, 9'd3,     16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SET_HOP,   9'd5,     16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SAMPLE,    9'd0,     16'h8000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SAMPLE,    9'd0,     16'h8000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SAMPLE,    9'd0,     16'h8000, 1'b1, 1'b1, 16'h8000},
    // size change in the middle of a chunk keeps the store and position
    '{ROW_SET_CHUNK, 9'd1,     16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SET_HOP,   9'd1,     16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SAMPLE,    9'd0,     16'h0064, 1'b0, 1'b0, 16'h0000},
    '{ROW_SAMPLE,    9'd0,     16'h00c8, 1'b0, 1'b0, 16'h0000},
    '{ROW_SET_CHUNK, 9'd6,     16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SAMPLE,    9'd0,     16'h012c, 1'b1, 1'b1, 16'h0064},
    // oversized writes clip to the maximum sizes
    '{ROW_SET_CHUNK, 9'd300,   16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SET_HOP,   9'h1c1,   16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_SAMPLE,    9'd0,     16'h0001, 1'b1, 1'b0, 16'h0000},
    '{ROW_SAMPLE,    9'd0,     16'hffff, 1'b1, 1'b0, 16'h0000}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata   = '0;   // [15:0] sample
  logic                  in_tlast   = 1'b0; // chunk_end
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SAMPLE_W-1:0]   out_tdata;         // [15:0] out_sample
  logic                  out_tlast;         // out_last
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // mirror of the block: accumulation store, fill position and size registers
  logic signed [ENTRY_W-1:0] acc_mirror [STORE_DEPTH];
  int unsigned               fill_pos;
  logic [CHUNK_CFG_W-1:0]    chunk_reg;
  logic [HOP_CFG_W-1:0]      hop_reg;

  out_beat_t burst [$];        // results caused by the latest input transfer
  out_beat_t owed_beats [$];   // results still to come out, oldest first
  int        mismatch_count = 0;
  int        src_idle_pct   = 0;
  int        sink_idle_pct  = 0;
  logic      touched        = 1'b0;   // input went in since the last settle

  overlap_add_accumulator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sizes as the block uses them: zero reads as one, oversize clips
  function automatic int unsigned live_chunk();
    if (chunk_reg == 0) return 1;
    if (chunk_reg > CHUNK_MAX) return CHUNK_MAX;
    return chunk_reg;
  endfunction

  function automatic int unsigned live_hop();
    if (hop_reg == 0) return 1;
    if (hop_reg > HOP_MAX) return HOP_MAX;
    return hop_reg;
  endfunction

  function automatic logic signed [ENTRY_W-1:0] clip_entry(int v);
    if (v > ENTRY_TOP) return ENTRY_W'(ENTRY_TOP);
    if (v < ENTRY_BOTTOM) return ENTRY_W'(ENTRY_BOTTOM);
    return ENTRY_W'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip_out(logic signed [ENTRY_W-1:0] e);
    int v;
    v = int'(e);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return SAMPLE_W'(v);
  endfunction

  // one sample into the mirror; a chunk end fills burst with hop results
  function automatic void overlap_add_step(logic [SAMPLE_W-1:0] smp, logic chunk_end);
    int unsigned hop;
    int unsigned span;
    int unsigned i;
    int          sum;
    hop  = live_hop();
    span = live_chunk() + hop;
    burst.delete();
    // past the active store the sample is dropped and the position holds
    if (fill_pos < span) begin
      sum = int'(acc_mirror[fill_pos]) + int'($signed(smp));
      acc_mirror[fill_pos] = clip_entry(sum);
      fill_pos++;
    end
    if (chunk_end) begin
      for (i = 0; i < hop; i++) begin
        burst.push_back('{smp: clip_out(acc_mirror[i]), last: (i + 1 == hop)});
      end
      // shift down by hop within the active length, zero the freed tail
      for (i = 0; i + hop < span; i++) begin
        acc_mirror[i] = acc_mirror[i + hop];
      end
      for (; i < span; i++) begin
        acc_mirror[i] = '0;
      end
      fill_pos = 0;
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(int unsigned lean);
    // a leaning chunk pushes entries into the 18-bit clip
    if (lean != 0 && $urandom_range(99) < 70) begin
      return (lean == 1) ? 16'h7fff : 16'h8000;
    end
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // present one sample, wait for the transfer, book its results
  task automatic feed_sample(logic [SAMPLE_W-1:0] smp, logic chunk_end,
                             logic pinned = 1'b0, logic [SAMPLE_W-1:0] first_out = '0);
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tlast  <= chunk_end;
    do @(posedge clk); while (!in_tready);
    overlap_add_step(smp, chunk_end);
    // a hand-typed value stands in for the first predicted result
    if (pinned && burst.size() != 0) burst[0].smp = first_out;
    foreach (burst[k]) owed_beats.push_back(burst[k]);
    touched = 1'b1;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
  endtask

  // register writes only land on an idle block
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    hold_until_drained();
    if (touched) repeat (SETTLE_CYCLES) @(posedge clk);
    touched = 1'b0;
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CHUNK) chunk_reg = val[CHUNK_CFG_W-1:0];
    else hop_reg = val[HOP_CFG_W-1:0];
    @(posedge clk);
  endtask

  // receiver side: random back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // result checker: every output transfer against the oldest booked result
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_beats.size() == 0) begin
        $error("unexpected output transfer: out_sample %0d out_last %0b",
               $signed(out_tdata), out_tlast);
        mismatch_count++;
      end else begin
        want = owed_beats.pop_front();
        if (out_tdata !== want.smp) begin
          $error("out_sample expected %0d actual %0d", $signed(want.smp), $signed(out_tdata));
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $error("out_last expected %0b actual %0b", want.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus: directed table, then random phases under three idling mixes
  initial begin
    int unsigned fed;
    int unsigned phase;
    int unsigned chunks;
    int unsigned c_eff;
    int unsigned span;
    int unsigned len;
    int unsigned lean;
    logic        leave_open;
    logic [CFG_DATA_W-1:0] c_val;
    logic [CFG_DATA_W-1:0] h_val;

    foreach (acc_mirror[i]) acc_mirror[i] = '0;
    fill_pos  = 0;
    chunk_reg = CHUNK_RESET;
    hop_reg   = HOP_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling on either side
    foreach (DIRECTED_PLAN[r]) begin
      case (DIRECTED_PLAN[r].kind)
        ROW_SET_CHUNK: write_reg(REG_CHUNK, DIRECTED_PLAN[r].value);
        ROW_SET_HOP:   write_reg(REG_HOP, DIRECTED_PLAN[r].value);
        default: begin
          feed_sample(DIRECTED_PLAN[r].smp, DIRECTED_PLAN[r].chunk_end,
                      DIRECTED_PLAN[r].pinned, DIRECTED_PLAN[r].first_out);
        end
      endcase
    end

    // random part: each phase picks sizes, then sends a few chunks
    fed   = 0;
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      if (fed >= 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (fed >= RANDOM_ITEMS / 3) begin
        src_idle_pct  = 70;
        sink_idle_pct = 11;
      end else begin
        src_idle_pct  = 11;
        sink_idle_pct = 70;
      end

      // first phases visit the size corners, the rest are mostly small
      case (phase)
        0: begin c_val = 9'd1;   h_val = 9'd1;   end
        1: begin c_val = 9'd256; h_val = 9'd64;  end
        2: begin c_val = 9'd256; h_val = 9'd1;   end
        3: begin c_val = 9'd1;   h_val = 9'd64;  end
        4: begin c_val = 9'h1ff; h_val = 9'h1ff; end
        default: begin
          if ($urandom_range(99) < 75) begin
            c_val = CFG_DATA_W'($urandom_range(1, 12));
            h_val = CFG_DATA_W'($urandom_range(1, 8));
          end else begin
            c_val = CFG_DATA_W'($urandom_range(0, 511));
            h_val = CFG_DATA_W'($urandom_range(0, 511));
          end
        end
      endcase
      write_reg(REG_CHUNK, c_val);
      write_reg(REG_HOP, h_val);

      lean   = $urandom_range(2);
      chunks = $urandom_range(2, 5);
      for (int unsigned n = 0; n < chunks; n++) begin
        c_eff = live_chunk();
        span  = c_eff + live_hop();
        case ($urandom_range(9))
          0, 1:    len = $urandom_range(1, c_eff);
          2, 3:    len = $urandom_range(span, span + 3);   // runs past the store when under the cap
          default: len = c_eff;
        endcase
        if (len > CHUNK_CAP) len = CHUNK_CAP;
        // sometimes the phase ends mid-chunk so the next size write lands there
        leave_open = (n + 1 == chunks) && ($urandom_range(99) < 15);
        for (int unsigned j = 0; j < len; j++) begin
          feed_sample(draw_sample(lean), (j + 1 == len) && !leave_open);
        end
        fed += (len < span) ? len : span;
        if (!leave_open && $urandom_range(99) < 5) hold_until_drained();
      end
      phase++;
    end

    // idling off; the sender waits until every owed result is out, then a settle wait
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("overlap_add_accumulator: match");
    end else begin
      $display("overlap_add_accumulator: mismatch");
    end
    $finish;
  end

  // watchdog on the whole run
  initial begin
    #(40ms);
    $display("overlap_add_accumulator: mismatch");
    $finish;
  end

endmodule

@@ overlap_add_accumulator.f @@
+incdir+rtl
rtl/oaa_pkg.sv
rtl/oaa_cell.sv
rtl/oaa_chain.sv
rtl/overlap_add_accumulator.sv
bench/overlap_add_accumulator_test.sv
